@@ sv/edls_pkg.sv @@
// shared types, constants and the length table of the detent length selector
package edls_pkg;

   // defaults of the top-level parameters
   localparam int TIME_BITS_DEFAULT      = 32;
   localparam int LENGTH_ENTRIES_DEFAULT = 4;

   // depth of the queue between front end and back end
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSES_PER_DETENT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IDLE_RESET_MS     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_STEP_GAP_MS   = 2'd2;

   // configuration reset values
   localparam logic [6:0]  PPD_RESET      = 7'd8;
   localparam logic [15:0] IDLE_RESET     = 16'd350;
   localparam logic [15:0] STEP_GAP_RESET = 16'd100;

   // stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   // step direction codes
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } step_dir_type;

   // classified encoder event, as handed from front end to back end
   typedef struct packed {
      logic signed [7:0] delta;
      logic              active;
      logic              delta_pos;
      logic              delta_neg;
   } event_class_type;

   localparam int CLASS_W = $bits(event_class_type);

   // one result, first member in the highest bits
   typedef struct packed {
      logic signed [7:0] accum_value;
      logic [4:0]        length_chars;
      logic [1:0]        length_index;
      logic              index_changed;
      step_dir_type      step_dir;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   // length table, entries past the fourth are 28 and then 31
   function automatic logic [4:0] length_lookup(input logic [3:0] idx);
      logic [4:0] chars;
      case (idx)
         4'd0:    chars = 5'd12;
         4'd1:    chars = 5'd16;
         4'd2:    chars = 5'd20;
         4'd3:    chars = 5'd24;
         4'd4:    chars = 5'd28;
         default: chars = 5'd31;
      endcase
      return chars;
   endfunction

endpackage

@@ sv/encoder_detent_length_selector_unit.sv @@
// Rotary encoder detent length selector. Each request is one encoder event
// (signed pulse count and millisecond timestamp in req_tdata, function layer
// flag in req_tuser) and gives exactly one response with the step direction,
// whether the length index moved, the index, the selected length and the
// accumulator. One request per clock is taken in sustained operation while
// rsp_tready stays high. Each request passes the queue and then the
// response register before its response is presented. The rate is set by
// the accumulator and index update in the back end. A two-entry queue after
// the front end keeps requests flowing while a response waits in the output
// register. Configuration is written through the csr_ port: 0 pulses per
// detent, 1 idle clear time, 2 least step gap.
module encoder_detent_length_selector_unit #(
   parameter int TIME_BITS      = edls_pkg::TIME_BITS_DEFAULT,
   parameter int LENGTH_ENTRIES = edls_pkg::LENGTH_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] pulse_delta, [39:8] time_ms
   input  logic [edls_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] layer_active
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] step_dir, [2] index_changed, [4:3] length_index,
   // [9:5] length_chars, [17:10] accum_value, [23:18] zero
   output logic [edls_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // configuration port
   input  logic                              csr_we,
   input  logic [edls_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [edls_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import edls_pkg::*;

   localparam int ENTRY_W = TIME_BITS + CLASS_W;

   logic [ENTRY_W-1:0] front_entry;
   logic [ENTRY_W-1:0] q_entry;
   logic               q_valid;
   logic               q_pop;
   result_type         result;

   // request classification
   edls_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .pulse_delta  ($signed(req_tdata[7:0])),
      .time_ms      (req_tdata[39:8]),
      .layer_active (req_tuser),
      .entry        (front_entry)
   );

   // queue between front end and back end
   edls_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_entry),
      .in_ready  (req_tready),
      .out_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_entry)
   );

   // state update and response register
   edls_back #(
      .TIME_BITS      (TIME_BITS),
      .LENGTH_ENTRIES (LENGTH_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (result)
   );

   // response packing
   assign rsp_tdata = {(RSP_TDATA_W - RESULT_W)'(0), result};

endmodule

@@ sv/edls_front.sv @@
// front end: takes an encoder event apart and classifies it for the queue
module edls_front #(
   parameter int TIME_BITS = edls_pkg::TIME_BITS_DEFAULT
) (
   input  logic signed [7:0]                         pulse_delta,
   input  logic [31:0]                               time_ms,
   input  logic                                      layer_active,
   output logic [TIME_BITS+edls_pkg::CLASS_W-1:0]    entry
);
   import edls_pkg::*;

   event_class_type        cls;
   logic [TIME_BITS-1:0]   now;

   // time reduced to the counter width
   assign now = TIME_BITS'(time_ms);

   // sign classification of the pulse count
   always_comb begin
      cls.delta     = pulse_delta;
      cls.active    = layer_active;
      cls.delta_neg = pulse_delta[7];
      cls.delta_pos = !pulse_delta[7] && (pulse_delta != 8'sd0);
   end

   // queue entry: time above the class fields
   assign entry = {now, cls};

endmodule

@@ sv/edls_queue.sv @@
// short fifo between the front end and the back end
module edls_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = edls_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   // handshake
   assign in_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/edls_back.sv @@
// back end: accumulator, step decision, length index and result register
module edls_back #(
   parameter int TIME_BITS      = edls_pkg::TIME_BITS_DEFAULT,
   parameter int LENGTH_ENTRIES = edls_pkg::LENGTH_ENTRIES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [edls_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [edls_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   q_valid,
   input  logic [TIME_BITS+edls_pkg::CLASS_W-1:0] q_entry,
   output logic                                   q_pop,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output edls_pkg::result_type                   rsp_result
);
   import edls_pkg::*;

   localparam int IDX_BITS = $clog2(LENGTH_ENTRIES);
   localparam int CNT_BITS = IDX_BITS + 1;

   // configuration
   logic [6:0]            ppd_ff;
   logic [15:0]           idle_ff;
   logic [15:0]           gap_ff;

   // block state
   logic signed [7:0]     accum_ff, accum_in;
   logic [TIME_BITS-1:0]  last_pulse_ff, last_pulse_in;
   logic [TIME_BITS-1:0]  last_step_ff, last_step_in;
   logic [IDX_BITS-1:0]   index_ff, index_in;

   // result register
   logic                  rsp_valid_ff;
   result_type            rsp_result_ff, rsp_result_in;

   // event fields
   event_class_type       cls;
   logic [TIME_BITS-1:0]  now;
   logic                  load;

   // working values
   logic [6:0]            ppd_eff;
   logic signed [7:0]     ppd_pos, ppd_neg;
   logic [TIME_BITS-1:0]  idle_gap, step_gap;
   logic signed [7:0]     acc_idle, acc_rev, acc_sat;
   logic signed [8:0]     acc_sum;
   logic                  gap_ok, at_up, at_down, can_up, can_down;
   step_dir_type          dir;
   logic                  moved;

   assign {now, cls} = q_entry;
   assign load       = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop      = load;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // detent size, zero acts as one
   assign ppd_eff = (ppd_ff == 7'd0) ? 7'd1 : ppd_ff;
   assign ppd_pos = $signed({1'b0, ppd_eff});
   assign ppd_neg = -ppd_pos;

   // modular time differences
   assign idle_gap = now - last_pulse_ff;
   assign step_gap = now - last_step_ff;
   assign gap_ok   = (step_gap >= TIME_BITS'(gap_ff));

   // idle clear, reversal clear and saturating add
   always_comb begin
      acc_idle = (idle_gap > TIME_BITS'(idle_ff)) ? 8'sd0 : accum_ff;
      acc_rev  = acc_idle;
      if (((acc_idle > 8'sd0) && cls.delta_neg) || ((acc_idle < 8'sd0) && cls.delta_pos)) begin
         acc_rev = 8'sd0;
      end
      acc_sum = {acc_rev[7], acc_rev} + {cls.delta[7], cls.delta};
      if (acc_sum[8] != acc_sum[7]) begin
         acc_sat = acc_sum[8] ? -8'sd128 : 8'sd127;
      end else begin
         acc_sat = acc_sum[7:0];
      end
   end

   // detent reached and index room
   assign at_up    = (acc_sat >= ppd_pos);
   assign at_down  = (acc_sat <= ppd_neg);
   assign can_up   = ((CNT_BITS'(index_ff) + 1'b1) < CNT_BITS'(LENGTH_ENTRIES));
   assign can_down = (index_ff != '0);

   // state update for one event
   always_comb begin
      accum_in      = accum_ff;
      last_pulse_in = last_pulse_ff;
      last_step_in  = last_step_ff;
      index_in      = index_ff;
      dir           = DIR_NONE;
      moved         = 1'b0;
      if (!cls.active) begin
         accum_in = 8'sd0;
      end else begin
         last_pulse_in = now;
         accum_in      = acc_sat;
         if (at_up && gap_ok) begin
            dir          = DIR_UP;
            last_step_in = now;
            accum_in     = 8'sd0;
            if (can_up) begin
               index_in = index_ff + 1'b1;
               moved    = 1'b1;
            end
         end else if (at_down && gap_ok) begin
            dir          = DIR_DOWN;
            last_step_in = now;
            accum_in     = 8'sd0;
            if (can_down) begin
               index_in = index_ff - 1'b1;
               moved    = 1'b1;
            end
         end
      end
   end

   // result fields
   always_comb begin
      rsp_result_in.accum_value   = accum_in;
      rsp_result_in.length_chars  = length_lookup(4'(index_in));
      rsp_result_in.length_index  = 2'(index_in);
      rsp_result_in.index_changed = moved;
      rsp_result_in.step_dir      = dir;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ppd_ff  <= PPD_RESET;
         idle_ff <= IDLE_RESET;
         gap_ff  <= STEP_GAP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PULSES_PER_DETENT: ppd_ff  <= csr_wdata[6:0];
            CSR_IDLE_RESET_MS:     idle_ff <= csr_wdata;
            CSR_MIN_STEP_GAP_MS:   gap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= 8'sd0;
         last_pulse_ff <= '0;
         last_step_ff  <= '0;
         index_ff      <= IDX_BITS'(1);
      end else if (load) begin
         accum_ff      <= accum_in;
         last_pulse_ff <= last_pulse_in;
         last_step_ff  <= last_step_in;
         index_ff      <= index_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

endmodule
